[hdl/ltsort_pkg.sv]
// Package for the lexicographic topological sort core.
// Holds the widths, the input kind codes and the command and state types.
// Used by ltsort_front, ltsort_back and the top level.
package ltsort_pkg;

	localparam int MAX_NODES = 32;
	localparam int NODE_W    = 5;
	localparam int IND_W     = 6;
	localparam int CFG_W     = 6;
	localparam int QDEPTH    = 4;
	localparam int QAW       = 2;

	localparam logic [CFG_W-1:0] NODES_RESET = 6'd26;
	localparam logic [CFG_W-1:0] NODES_LIMIT = 6'd32;
	localparam logic [IND_W-1:0] IND_MAX     = 6'd63;

	localparam logic [1:0] KIND_EDGE  = 2'd0;
	localparam logic [1:0] KIND_RUN   = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		OP_EDGE,
		OP_RUN,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [NODE_W-1:0] from_node;
		logic [NODE_W-1:0] to_node;
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

endpackage

[hdl/ltsort_front.sv]
// Front end of the sort core: accepts input words, decodes their kind and
// queues the commands for the back end. Unused kinds are dropped here.
// Depends on ltsort_pkg.
module ltsort_front import ltsort_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [NODE_W-1:0] from_node,
	input  logic [NODE_W-1:0] to_node,
	output logic              cmd_valid,
	output cmd_t              cmd,
	input  logic              cmd_pop
);

	cmd_t           queue_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           accept;
	logic           store;
	logic           pop;
	cmd_t           decoded;

	assign in_ready  = (count_q != (QAW+1)'(QDEPTH));
	assign accept    = in_valid && in_ready;
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign pop       = cmd_pop && cmd_valid;

	always_comb begin
		decoded.from_node = from_node;
		decoded.to_node   = to_node;
		decoded.op        = OP_EDGE;
		store             = 1'b1;
		unique case (kind)
			KIND_EDGE:  decoded.op = OP_EDGE;
			KIND_RUN:   decoded.op = OP_RUN;
			KIND_CLEAR: decoded.op = OP_CLEAR;
			default:    store = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept && store) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if ((accept && store) && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!(accept && store) && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && store) begin
			queue_q[wr_ptr_q] <= decoded;
		end
	end

endmodule

[hdl/ltsort_back.sv]
// Back end of the sort core: holds the graph, the node count register and
// the sort engine, and drives the registered result word.
// Depends on ltsort_pkg; fed by ltsort_front.
module ltsort_back import ltsort_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  nodes_in_use,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NODE_W-1:0] node,
	output logic              node_valid,
	output logic              last,
	output logic              blocked
);

	logic [MAX_NODES-1:0] rows_q [MAX_NODES];
	logic [IND_W-1:0]     base_q [MAX_NODES];
	logic [IND_W-1:0]     work_q [MAX_NODES];
	logic [IND_W-1:0]     work_n [MAX_NODES];
	logic [MAX_NODES-1:0] rem_q;
	logic [CFG_W-1:0]     nodes_q;
	logic [NODE_W-1:0]    pend_node_q;
	logic                 pend_valid_q;
	logic                 out_valid_q;
	logic [NODE_W-1:0]    out_node_q;
	logic                 out_nvalid_q;
	logic                 out_last_q;
	logic                 out_blocked_q;
	state_t               state_q;
	state_t               state_n;

	logic                 out_free;
	logic                 take;
	logic                 start_run;
	logic                 step;
	logic [MAX_NODES-1:0] ready_vec;
	logic                 any_ready;
	logic [NODE_W-1:0]    sel;
	logic [MAX_NODES-1:0] sel_row;
	logic [CFG_W-1:0]     n_clip;
	logic [MAX_NODES:0]   mask_wide;
	logic [MAX_NODES-1:0] active;
	logic                 edge_new;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign take      = cmd_valid && (state_q == ST_IDLE);
	assign cmd_pop   = take;
	assign start_run = take && (cmd.op == OP_RUN);
	assign step      = (state_q == ST_RUN) && out_free;

	assign n_clip    = (nodes_q > NODES_LIMIT) ? NODES_LIMIT : nodes_q;
	assign mask_wide = ((MAX_NODES+1)'(1) << n_clip) - (MAX_NODES+1)'(1);
	assign active    = mask_wide[MAX_NODES-1:0];
	assign edge_new  = !rows_q[cmd.from_node][cmd.to_node];

	always_comb begin
		for (int i = 0; i < MAX_NODES; i++) begin
			ready_vec[i] = (work_q[i] == '0) && rem_q[i];
		end
		any_ready = (ready_vec != '0);
		sel = '0;
		for (int i = MAX_NODES-1; i >= 0; i--) begin
			if (ready_vec[i]) begin
				sel = NODE_W'(i);
			end
		end
		sel_row = rows_q[sel];
		for (int i = 0; i < MAX_NODES; i++) begin
			work_n[i] = work_q[i];
			if (sel_row[i] && (work_q[i] != '0)) begin
				work_n[i] = work_q[i] - 1'b1;
			end
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start_run) begin
					state_n = ST_RUN;
				end
			end
			ST_RUN: begin
				if (step && !any_ready) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			nodes_q      <= NODES_RESET;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			for (int i = 0; i < MAX_NODES; i++) begin
				rows_q[i] <= '0;
				base_q[i] <= '0;
			end
		end else begin
			state_q <= state_n;
			if (cfg_valid) begin
				nodes_q <= nodes_in_use;
			end
			if (take && (cmd.op == OP_EDGE) && edge_new) begin
				rows_q[cmd.from_node][cmd.to_node] <= 1'b1;
				if (base_q[cmd.to_node] < IND_MAX) begin
					base_q[cmd.to_node] <= base_q[cmd.to_node] + 1'b1;
				end
			end
			if (take && (cmd.op == OP_CLEAR)) begin
				for (int i = 0; i < MAX_NODES; i++) begin
					rows_q[i] <= '0;
					base_q[i] <= '0;
				end
			end
			if (start_run) begin
				pend_valid_q <= 1'b0;
			end else if (step) begin
				pend_valid_q <= any_ready;
			end
			if (step && (any_ready ? pend_valid_q : 1'b1)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_run) begin
			work_q <= base_q;
			rem_q  <= active;
		end else if (step && any_ready) begin
			work_q     <= work_n;
			rem_q[sel] <= 1'b0;
		end
		if (step) begin
			if (any_ready) begin
				pend_node_q   <= sel;
				out_node_q    <= pend_node_q;
				out_nvalid_q  <= 1'b1;
				out_last_q    <= 1'b0;
				out_blocked_q <= 1'b0;
			end else begin
				out_node_q    <= pend_valid_q ? pend_node_q : '0;
				out_nvalid_q  <= pend_valid_q;
				out_last_q    <= 1'b1;
				out_blocked_q <= (rem_q != '0);
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign node       = out_node_q;
	assign node_valid = out_nvalid_q;
	assign last       = out_last_q;
	assign blocked    = out_blocked_q;

endmodule

[hdl/lexicographic_topological_sort_core.sv]
// Top level of the lexicographic topological sort core.
// Connects the decoding front end to the graph and sort back end.
// Depends on ltsort_pkg, ltsort_front and ltsort_back.
//
// Input words arrive on in_valid/in_ready with kind, from_node and to_node.
// Kind 0 stores an edge, kind 1 starts a sort run, kind 2 empties the graph;
// kind 3 is accepted and dropped. Words pass through a four-entry queue, so
// the input keeps accepting while a run is busy until the queue is full.
// Edge and clear words retire one per cycle while no run is busy. A run
// loads its working copy, then selects one node per cycle while the output
// is not stalled, always the lowest-numbered ready node, and updates the
// indegrees of its successors; each emitted node is shown one step later,
// when it is known whether another ready node follows. A run that emits
// nothing gives one word with last set. The nodes_in_use register is
// written on cfg_valid/cfg_ready; the user is to write it only while idle,
// which the block itself does not enforce. Results leave on out_valid/
// out_ready from an output register; while the receiver stalls, the sort
// engine holds its step and loses nothing. Reset empties the graph, the
// queue and the output, and sets nodes_in_use to 26.
module lexicographic_topological_sort_core import ltsort_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  nodes_in_use,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [NODE_W-1:0] from_node,
	input  logic [NODE_W-1:0] to_node,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NODE_W-1:0] node,
	output logic              node_valid,
	output logic              last,
	output logic              blocked
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	ltsort_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.from_node (from_node),
		.to_node   (to_node),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	ltsort_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.nodes_in_use (nodes_in_use),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.node         (node),
		.node_valid   (node_valid),
		.last         (last),
		.blocked      (blocked)
	);

endmodule

[verif/lexicographic_topological_sort_core_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for lexicographic_topological_sort_core: edges, sort runs,
// clears and nodes_in_use writes under random valid/ready idling, with results checked
// in order against a lowest-index-first topological sort predictor. Needs ltsort_pkg.
module lexicographic_topological_sort_core_test;

	import ltsort_pkg::*;

	localparam logic [1:0] KIND_UNUSED    = 2'd3;
	localparam int         DRAIN_CYCLES   = 16;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         WORD_TARGET    = 330;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic              valid;
		logic              last;
		logic              blocked;
	} sort_word_t;

	class order_scoreboard;
		logic [MAX_NODES-1:0] succ_row [MAX_NODES];
		logic [IND_W-1:0]     pred_count [MAX_NODES];
		logic [CFG_W-1:0]     nodes_cfg;
		sort_word_t           order_words [$];
		int unsigned          mismatches;
		int unsigned          runs_seen;
		int unsigned          blocked_runs;
		int unsigned          words_checked;

		function new();
			clear_graph();
			nodes_cfg = NODES_RESET;
		endfunction

		function void clear_graph();
			for (int i = 0; i < MAX_NODES; i++) begin
				succ_row[i] = '0;
				pred_count[i] = '0;
			end
		endfunction

		function void set_nodes(input logic [CFG_W-1:0] v);
			nodes_cfg = v;
		endfunction

		function int unsigned active_count();
			return (nodes_cfg > NODES_LIMIT) ? int'(NODES_LIMIT) : int'(nodes_cfg);
		endfunction

		function int unsigned pending();
			return order_words.size();
		endfunction

		function void predict_sort_order();
			logic [IND_W-1:0]     work [MAX_NODES];
			logic [MAX_NODES-1:0] unsent;
			logic [MAX_NODES-1:0] ready;
			sort_word_t           held;
			bit                   have_held;
			int                   m;
			have_held = 0;
			held = '0;
			for (int i = 0; i < MAX_NODES; i++)
				work[i] = pred_count[i];
			unsent = (active_count() == MAX_NODES) ? '1 : ((32'd1 << active_count()) - 32'd1);
			forever begin
				ready = '0;
				for (int i = 0; i < MAX_NODES; i++)
					ready[i] = (work[i] == '0);
				ready &= unsent;
				if (ready == '0)
					break;
				m = 0;
				for (int i = MAX_NODES - 1; i >= 0; i--)
					if (ready[i])
						m = i;
				unsent[m] = 1'b0;
				for (int i = 0; i < MAX_NODES; i++)
					if (succ_row[m][i] && work[i] != '0)
						work[i] = work[i] - 1'b1;
				if (have_held)
					order_words.push_back(held);
				held = '{node: m[NODE_W-1:0], valid: 1'b1, last: 1'b0, blocked: 1'b0};
				have_held = 1;
			end
			held.last = 1'b1;
			held.blocked = |unsent;
			order_words.push_back(held);
			runs_seen++;
			if (|unsent)
				blocked_runs++;
		endfunction

		function void note_input(input logic [1:0] k, input logic [NODE_W-1:0] f,
				input logic [NODE_W-1:0] t);
			case (k)
				KIND_EDGE: begin
					if (!succ_row[f][t]) begin
						succ_row[f][t] = 1'b1;
						if (pred_count[t] != IND_MAX)
							pred_count[t] = pred_count[t] + 1'b1;
					end
				end
				KIND_CLEAR: clear_graph();
				KIND_RUN: predict_sort_order();
				default: ;
			endcase
		endfunction

		task report(input string what);
			mismatches++;
			if (mismatches <= 50)
				$display("%0t: mismatch: %s", $time, what);
		endtask

		task check_word(input sort_word_t got);
			sort_word_t want;
			words_checked++;
			if (order_words.size() == 0) begin
				report($sformatf("unexpected word node=%0d valid=%0b last=%0b blocked=%0b",
					got.node, got.valid, got.last, got.blocked));
			end else begin
				want = order_words.pop_front();
				if (got.node != want.node)
					report($sformatf("node %0d, expected %0d", got.node, want.node));
				if (got.valid != want.valid)
					report($sformatf("node_valid %0b, expected %0b", got.valid, want.valid));
				if (got.last != want.last)
					report($sformatf("last %0b, expected %0b", got.last, want.last));
				if (got.blocked != want.blocked)
					report($sformatf("blocked %0b, expected %0b", got.blocked, want.blocked));
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  nodes_in_use = '0;
	logic              in_valid     = 1'b0;
	logic              in_ready;
	logic [1:0]        kind         = KIND_EDGE;
	logic [NODE_W-1:0] from_node    = '0;
	logic [NODE_W-1:0] to_node      = '0;
	logic              out_valid;
	logic              out_ready    = 1'b0;
	logic [NODE_W-1:0] node;
	logic              node_valid;
	logic              last;
	logic              blocked;

	order_scoreboard sb = new();
	int unsigned     send_idle_pct = 0;
	int unsigned     recv_idle_pct = 0;
	int unsigned     words_sent    = 0;
	int unsigned     cfg_writes    = 0;
	int unsigned     quiet_cycles  = 0;
	bit              in_held       = 0;

	lexicographic_topological_sort_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.nodes_in_use(nodes_in_use),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.from_node(from_node),
		.to_node(to_node),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.node(node),
		.node_valid(node_valid),
		.last(last),
		.blocked(blocked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_word('{node: node, valid: node_valid, last: last, blocked: blocked});
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("lexicographic_topological_sort_core test failed");
			$finish;
		end
	end

	task automatic drop_input();
		if (in_held) begin
			in_valid <= 1'b0;
			in_held = 0;
		end
	endtask

	task automatic send_word(input logic [1:0] k, input logic [NODE_W-1:0] f,
			input logic [NODE_W-1:0] t);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			drop_input();
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_held = 1;
		kind <= k;
		from_node <= f;
		to_node <= t;
		do @(posedge clk); while (!in_ready);
		sb.note_input(k, f, t);
		if (k != KIND_UNUSED)
			words_sent++;
	endtask

	task automatic wait_idle();
		drop_input();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_nodes(input logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		nodes_in_use <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_nodes(v);
		cfg_writes++;
	endtask

	task automatic random_batch();
		int unsigned order [MAX_NODES];
		int unsigned span, i, j, r, tmp;
		if ($urandom_range(3) == 0) begin
			wait_idle();
			r = $urandom_range(9);
			if (r < 7)
				write_nodes(CFG_W'($urandom_range(1, 32)));
			else if (r == 7)
				write_nodes('0);
			else
				write_nodes(CFG_W'($urandom_range(33, 63)));
		end
		span = sb.active_count();
		if (span < 2)
			span = 2;
		for (i = 0; i < MAX_NODES; i++)
			order[i] = i;
		for (i = span - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		if ($urandom_range(4) != 0)
			send_word(KIND_CLEAR, NODE_W'($urandom_range(31)), NODE_W'($urandom_range(31)));
		repeat ($urandom_range(1, 2)) begin
			repeat ($urandom_range(0, 10)) begin
				r = $urandom_range(99);
				i = $urandom_range(0, span - 2);
				j = $urandom_range(i + 1, span - 1);
				if (r < 72)
					send_word(KIND_EDGE, NODE_W'(order[i]), NODE_W'(order[j]));
				else if (r < 82)
					send_word(KIND_EDGE, NODE_W'(order[j]), NODE_W'(order[i]));
				else if (r < 87)
					send_word(KIND_EDGE, NODE_W'(order[i]), NODE_W'(order[i]));
				else if (r < 94)
					send_word(KIND_EDGE, NODE_W'($urandom_range(31)),
						NODE_W'($urandom_range(31)));
				else
					send_word(KIND_UNUSED, NODE_W'($urandom_range(31)),
						NODE_W'($urandom_range(31)));
			end
			send_word(KIND_RUN, NODE_W'($urandom_range(31)), NODE_W'($urandom_range(31)));
		end
	endtask

	initial begin
		send_idle_pct = 34;
		recv_idle_pct = 55;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_word(KIND_RUN, 5'd0, 5'd0);
		send_word(KIND_EDGE, 5'd3, 5'd1);
		send_word(KIND_EDGE, 5'd3, 5'd1);
		send_word(KIND_EDGE, 5'd1, 5'd0);
		send_word(KIND_EDGE, 5'd2, 5'd2);
		send_word(KIND_EDGE, 5'd31, 5'd5);
		send_word(KIND_UNUSED, 5'd31, 5'd31);
		send_word(KIND_EDGE, 5'd0, 5'd31);
		send_word(KIND_RUN, 5'd31, 5'd31);
		send_word(KIND_CLEAR, 5'd0, 5'd0);
		send_word(KIND_RUN, 5'd0, 5'd0);
		wait_idle();
		write_nodes(6'd0);
		send_word(KIND_RUN, 5'd0, 5'd0);
		wait_idle();
		write_nodes(6'd63);
		send_word(KIND_EDGE, 5'd0, 5'd31);
		send_word(KIND_EDGE, 5'd31, 5'd30);
		send_word(KIND_EDGE, 5'd17, 5'd16);
		send_word(KIND_RUN, 5'd0, 5'd0);
		wait_idle();
		write_nodes(6'd1);
		send_word(KIND_EDGE, 5'd0, 5'd0);
		send_word(KIND_RUN, 5'd0, 5'd0);
		wait_idle();
		write_nodes(6'd32);
		send_word(KIND_CLEAR, 5'd31, 5'd31);
		send_word(KIND_EDGE, 5'd4, 5'd5);
		send_word(KIND_EDGE, 5'd5, 5'd4);
		send_word(KIND_RUN, 5'd0, 5'd0);

		while (words_sent < WORD_TARGET / 3 + 15)
			random_batch();
		wait_idle();
		send_idle_pct = 55;
		recv_idle_pct = 34;
		while (words_sent < 2 * WORD_TARGET / 3 + 10)
			random_batch();
		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (words_sent < WORD_TARGET)
			random_batch();
		wait_idle();

		$display("Sent %0d input words and %0d nodes_in_use writes under three idling mixes.",
			words_sent, cfg_writes);
		$display("Checked %0d result words from %0d sort runs, %0d of them ending blocked.",
			sb.words_checked, sb.runs_seen, sb.blocked_runs);
		if (sb.mismatches == 0)
			$display("lexicographic_topological_sort_core test passed");
		else
			$display("lexicographic_topological_sort_core test failed");
		$finish;
	end

endmodule
